// ===== src/tlsf_pkg.sv =====
package tlsf_pkg;

    // Index geometry.
    localparam int FIRST_LEVELS = 24;
    localparam int SL_BITS      = 4;
    localparam int BLOCK_COUNT  = 256;
    localparam int SL_COUNT     = 1 << SL_BITS;
    localparam int BIN_COUNT    = FIRST_LEVELS * SL_COUNT;

    // Field widths of the request and result channels.
    localparam int REQ_W    = 2;
    localparam int SIZE_W   = 24;
    localparam int HANDLE_W = 8;

    // Derived widths.
    localparam int BLK_W    = $clog2(BLOCK_COUNT);
    localparam int FL_W     = $clog2(FIRST_LEVELS);
    localparam int FL_LIMIT = (SIZE_W > FIRST_LEVELS) ? SIZE_W : FIRST_LEVELS;
    localparam int FLX_W    = $clog2(FL_LIMIT + 1);
    localparam int FLS_W    = FL_W + 1;
    localparam int BIN_W    = FL_W + SL_BITS;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FIND   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

    // Result status codes.
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_MISS = 1'b1;

    typedef struct packed {
        logic             valid;
        logic [BLK_W-1:0] handle;
    } link_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_INS_A,
        WR_INS_B,
        WR_REM_A,
        WR_REM_B,
        WR_POP_A,
        WR_POP_B
    } wr_op_t;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_DONE,
        RES_MISS,
        RES_TAKE
    } res_kind_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LEVEL,
        S_SLOT,
        S_SEARCH,
        S_PICK,
        S_INS_HEAD,
        S_INS_WR_A,
        S_INS_WR_B,
        S_REM_WR_A,
        S_REM_WR_B,
        S_POP_HEAD,
        S_POP_NEXT,
        S_POP_WR_A,
        S_POP_WR_B,
        S_RES_DONE,
        S_RES_MISS,
        S_RES_TAKE
    } ctrl_state_t;

    typedef struct packed {
        logic      load_req;
        logic      load_level;
        logic      rd_links;
        logic      load_bin;
        logic      load_search;
        logic      load_pick;
        logic      rd_head;
        logic      rd_next;
        wr_op_t    wr_op;
        res_kind_t res_kind;
    } dp_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             link_prev_valid;
        logic             fl_miss;
        logic             pick_hit;
        logic             rem_match;
        logic             out_free;
    } dp_stat_t;

    // Index of the highest set bit of a size.
    function automatic logic [FLX_W-1:0] top_bit(input logic [SIZE_W-1:0] v);
        logic [FLX_W-1:0] b;
        b = '0;
        for (int i = 0; i < SIZE_W; i++)
        begin
            if (v[i])
            begin
                b = FLX_W'(i);
            end
        end
        return b;
    endfunction

    // Index of the lowest set bit of a first-level mask.
    function automatic logic [FL_W-1:0] low_bit_fl(input logic [FIRST_LEVELS-1:0] v);
        logic [FL_W-1:0] b;
        b = '0;
        for (int i = FIRST_LEVELS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                b = FL_W'(i);
            end
        end
        return b;
    endfunction

    // Index of the lowest set bit of a second-level mask.
    function automatic logic [SL_BITS-1:0] low_bit_sl(input logic [SL_COUNT-1:0] v);
        logic [SL_BITS-1:0] b;
        b = '0;
        for (int i = SL_COUNT - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                b = SL_BITS'(i);
            end
        end
        return b;
    endfunction

endpackage

// ===== src/tlsf_ctrl.sv =====
module tlsf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  tlsf_pkg::dp_stat_t stat,
    output tlsf_pkg::dp_cmd_t  cmd
);

    tlsf_pkg::ctrl_state_t state_reg;
    tlsf_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tlsf_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tlsf_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tlsf_pkg::S_LEVEL;
                end
            end
            tlsf_pkg::S_LEVEL:
            begin
                state_next = tlsf_pkg::S_SLOT;
            end
            tlsf_pkg::S_SLOT:
            begin
                priority if (stat.req_type == tlsf_pkg::REQ_INSERT)
                begin
                    state_next = tlsf_pkg::S_INS_HEAD;
                end
                else if (stat.req_type == tlsf_pkg::REQ_FIND)
                begin
                    state_next = tlsf_pkg::S_SEARCH;
                end
                else if (stat.req_type == tlsf_pkg::REQ_REMOVE)
                begin
                    state_next = stat.link_prev_valid ? tlsf_pkg::S_REM_WR_A
                                                      : tlsf_pkg::S_POP_HEAD;
                end
                else
                begin
                    state_next = tlsf_pkg::S_RES_DONE;
                end
            end
            tlsf_pkg::S_SEARCH:
            begin
                state_next = stat.fl_miss ? tlsf_pkg::S_RES_MISS : tlsf_pkg::S_PICK;
            end
            tlsf_pkg::S_PICK:
            begin
                state_next = stat.pick_hit ? tlsf_pkg::S_POP_HEAD : tlsf_pkg::S_RES_MISS;
            end
            tlsf_pkg::S_INS_HEAD:
            begin
                state_next = tlsf_pkg::S_INS_WR_A;
            end
            tlsf_pkg::S_INS_WR_A:
            begin
                state_next = tlsf_pkg::S_INS_WR_B;
            end
            tlsf_pkg::S_INS_WR_B:
            begin
                state_next = tlsf_pkg::S_RES_DONE;
            end
            tlsf_pkg::S_REM_WR_A:
            begin
                state_next = tlsf_pkg::S_REM_WR_B;
            end
            tlsf_pkg::S_REM_WR_B:
            begin
                state_next = tlsf_pkg::S_RES_DONE;
            end
            tlsf_pkg::S_POP_HEAD:
            begin
                state_next = tlsf_pkg::S_POP_NEXT;
            end
            tlsf_pkg::S_POP_NEXT:
            begin
                // A remove whose block is not the head of its bin does nothing.
                if (stat.req_type == tlsf_pkg::REQ_REMOVE && !stat.rem_match)
                begin
                    state_next = tlsf_pkg::S_RES_DONE;
                end
                else
                begin
                    state_next = tlsf_pkg::S_POP_WR_A;
                end
            end
            tlsf_pkg::S_POP_WR_A:
            begin
                state_next = tlsf_pkg::S_POP_WR_B;
            end
            tlsf_pkg::S_POP_WR_B:
            begin
                state_next = (stat.req_type == tlsf_pkg::REQ_FIND) ? tlsf_pkg::S_RES_TAKE
                                                                   : tlsf_pkg::S_RES_DONE;
            end
            tlsf_pkg::S_RES_DONE,
            tlsf_pkg::S_RES_MISS,
            tlsf_pkg::S_RES_TAKE:
            begin
                if (stat.out_free)
                begin
                    state_next = tlsf_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tlsf_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.wr_op    = tlsf_pkg::WR_NONE;
        cmd.res_kind = tlsf_pkg::RES_NONE;
        in_stall = 1'b1;
        unique case (state_reg)
            tlsf_pkg::S_IDLE:
            begin
                in_stall     = 1'b0;
                cmd.load_req = in_valid;
            end
            tlsf_pkg::S_LEVEL:
            begin
                cmd.load_level = 1'b1;
                cmd.rd_links   = 1'b1;
            end
            tlsf_pkg::S_SLOT:
            begin
                cmd.load_bin = 1'b1;
            end
            tlsf_pkg::S_SEARCH:
            begin
                cmd.load_search = 1'b1;
            end
            tlsf_pkg::S_PICK:
            begin
                cmd.load_pick = 1'b1;
            end
            tlsf_pkg::S_INS_HEAD,
            tlsf_pkg::S_POP_HEAD:
            begin
                cmd.rd_head = 1'b1;
            end
            tlsf_pkg::S_INS_WR_A:
            begin
                cmd.wr_op = tlsf_pkg::WR_INS_A;
            end
            tlsf_pkg::S_INS_WR_B:
            begin
                cmd.wr_op = tlsf_pkg::WR_INS_B;
            end
            tlsf_pkg::S_REM_WR_A:
            begin
                cmd.wr_op = tlsf_pkg::WR_REM_A;
            end
            tlsf_pkg::S_REM_WR_B:
            begin
                cmd.wr_op = tlsf_pkg::WR_REM_B;
            end
            tlsf_pkg::S_POP_NEXT:
            begin
                cmd.rd_next = 1'b1;
            end
            tlsf_pkg::S_POP_WR_A:
            begin
                cmd.wr_op = tlsf_pkg::WR_POP_A;
            end
            tlsf_pkg::S_POP_WR_B:
            begin
                cmd.wr_op = tlsf_pkg::WR_POP_B;
            end
            tlsf_pkg::S_RES_DONE:
            begin
                cmd.res_kind = stat.out_free ? tlsf_pkg::RES_DONE : tlsf_pkg::RES_NONE;
            end
            tlsf_pkg::S_RES_MISS:
            begin
                cmd.res_kind = stat.out_free ? tlsf_pkg::RES_MISS : tlsf_pkg::RES_NONE;
            end
            tlsf_pkg::S_RES_TAKE:
            begin
                cmd.res_kind = stat.out_free ? tlsf_pkg::RES_TAKE : tlsf_pkg::RES_NONE;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== src/tlsf_dp.sv =====
module tlsf_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [tlsf_pkg::REQ_W-1:0]     req_type,
    input  logic [tlsf_pkg::SIZE_W-1:0]    block_size,
    input  logic [tlsf_pkg::HANDLE_W-1:0]  block_handle,
    input  tlsf_pkg::dp_cmd_t              cmd,
    output tlsf_pkg::dp_stat_t             stat,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [tlsf_pkg::HANDLE_W-1:0]  taken_handle,
    output logic                           status
);

    // Request registers.
    logic [tlsf_pkg::REQ_W-1:0]  req_type_reg;
    logic [tlsf_pkg::SIZE_W-1:0] size_reg;
    logic [tlsf_pkg::BLK_W-1:0]  handle_reg;

    // Mapping and search registers.
    logic [tlsf_pkg::FLX_W-1:0]   lvl_reg;
    logic [tlsf_pkg::FL_W-1:0]    fl_reg;
    logic [tlsf_pkg::SL_BITS-1:0] sl_reg;
    logic                         miss_reg;
    logic                         srch_sl_hit_reg;
    logic [tlsf_pkg::SL_BITS-1:0] srch_sl_reg;
    logic                         srch_fl_hit_reg;
    logic [tlsf_pkg::FL_W-1:0]    srch_fl_reg;

    // Bitmaps; a bin's head is valid exactly when its second-level bit is set.
    logic [tlsf_pkg::FIRST_LEVELS-1:0] flmap_reg;
    logic [tlsf_pkg::SL_COUNT-1:0]     slmap_reg [tlsf_pkg::FIRST_LEVELS];

    // Memories and their read data.
    logic [tlsf_pkg::BLK_W-1:0] head_mem [tlsf_pkg::BIN_COUNT];
    tlsf_pkg::link_t            next_mem [tlsf_pkg::BLOCK_COUNT];
    tlsf_pkg::link_t            prev_mem [tlsf_pkg::BLOCK_COUNT];
    logic [tlsf_pkg::BLK_W-1:0] head_rdata_reg;
    logic                       head_valid_reg;
    tlsf_pkg::link_t            next_rdata_reg;
    tlsf_pkg::link_t            prev_rdata_reg;

    // Result register.
    logic                          out_valid_reg;
    logic [tlsf_pkg::HANDLE_W-1:0] taken_handle_reg;
    logic                          status_reg;

    // Combinational signals.
    logic [tlsf_pkg::SIZE_W-1:0]       raised;
    logic [tlsf_pkg::FLX_W-1:0]        level_next;
    logic [tlsf_pkg::FLX_W-1:0]        shift_k;
    logic [tlsf_pkg::SIZE_W-1:0]       quot;
    logic [tlsf_pkg::SL_BITS-1:0]      sl_raw;
    logic                              rem_nz;
    logic [tlsf_pkg::FLX_W-1:0]        map_fl_x;
    logic [tlsf_pkg::SL_BITS-1:0]      map_sl;
    logic                              map_miss;
    logic [tlsf_pkg::FL_W-1:0]         row_addr;
    logic [tlsf_pkg::SL_COUNT-1:0]     sl_row;
    logic [tlsf_pkg::SL_COUNT-1:0]     slm;
    logic [tlsf_pkg::SL_COUNT-1:0]     sl_clr;
    logic [tlsf_pkg::FIRST_LEVELS-1:0] flm;
    logic [tlsf_pkg::BIN_W-1:0]        bin_addr;
    logic [tlsf_pkg::BLK_W-1:0]        next_ra;

    logic                       head_we;
    logic [tlsf_pkg::BLK_W-1:0] head_wd;
    logic                       next_we;
    logic [tlsf_pkg::BLK_W-1:0] next_wa;
    tlsf_pkg::link_t            next_wd;
    logic                       prev_we;
    logic [tlsf_pkg::BLK_W-1:0] prev_wa;
    tlsf_pkg::link_t            prev_wd;

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_type_reg <= req_type;
            size_reg     <= block_size;
            handle_reg   <= tlsf_pkg::BLK_W'(block_handle);
        end
    end

    // Size mapping: first level is the top bit, second level the bits below it.
    assign raised = (size_reg < tlsf_pkg::SIZE_W'(tlsf_pkg::SL_COUNT))
                    ? tlsf_pkg::SIZE_W'(tlsf_pkg::SL_COUNT) : size_reg;
    assign level_next = tlsf_pkg::top_bit(raised);
    assign shift_k    = lvl_reg - tlsf_pkg::FLX_W'(tlsf_pkg::SL_BITS);
    assign quot       = raised >> shift_k;
    assign sl_raw     = quot[tlsf_pkg::SL_BITS-1:0];
    assign rem_nz     = |(raised & ~({tlsf_pkg::SIZE_W{1'b1}} << shift_k));

    always_comb
    begin
        map_fl_x = lvl_reg;
        map_sl   = sl_raw;
        if (req_type_reg == tlsf_pkg::REQ_FIND)
        begin
            // Find rounds up to the next bin boundary.
            if (rem_nz)
            begin
                if (&sl_raw)
                begin
                    map_fl_x = lvl_reg + tlsf_pkg::FLX_W'(1);
                    map_sl   = '0;
                end
                else
                begin
                    map_sl = sl_raw + tlsf_pkg::SL_BITS'(1);
                end
            end
        end
        else if (lvl_reg >= tlsf_pkg::FLX_W'(tlsf_pkg::FIRST_LEVELS))
        begin
            map_fl_x = tlsf_pkg::FLX_W'(tlsf_pkg::FIRST_LEVELS - 1);
            map_sl   = '1;
        end
    end

    assign map_miss = map_fl_x >= tlsf_pkg::FLX_W'(tlsf_pkg::FIRST_LEVELS);

    // Single read port on the second-level bitmaps.
    assign row_addr = cmd.load_pick ? srch_fl_reg : fl_reg;
    assign sl_row   = slmap_reg[row_addr];
    assign slm      = sl_row & ({tlsf_pkg::SL_COUNT{1'b1}} << sl_reg);
    assign sl_clr   = sl_row & ~(tlsf_pkg::SL_COUNT'(1) << sl_reg);
    assign flm      = flmap_reg & ({tlsf_pkg::FIRST_LEVELS{1'b1}}
                      << (tlsf_pkg::FLS_W'(fl_reg) + tlsf_pkg::FLS_W'(1)));
    assign bin_addr = {fl_reg, sl_reg};
    assign next_ra  = cmd.rd_next ? head_rdata_reg : handle_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_level)
        begin
            lvl_reg <= level_next;
        end
        if (cmd.load_bin)
        begin
            fl_reg   <= map_fl_x[tlsf_pkg::FL_W-1:0];
            sl_reg   <= map_sl;
            miss_reg <= map_miss;
        end
        else if (cmd.load_pick)
        begin
            if (srch_sl_hit_reg)
            begin
                sl_reg <= srch_sl_reg;
            end
            else
            begin
                fl_reg <= srch_fl_reg;
                sl_reg <= tlsf_pkg::low_bit_sl(sl_row);
            end
        end
        if (cmd.load_search)
        begin
            srch_sl_hit_reg <= |slm;
            srch_sl_reg     <= tlsf_pkg::low_bit_sl(slm);
            srch_fl_hit_reg <= |flm;
            srch_fl_reg     <= tlsf_pkg::low_bit_fl(flm);
        end
        if (cmd.rd_head)
        begin
            head_valid_reg <= sl_row[sl_reg];
        end
    end

    always_comb
    begin
        head_we = 1'b0;
        head_wd = handle_reg;
        next_we = 1'b0;
        next_wa = handle_reg;
        next_wd = '0;
        prev_we = 1'b0;
        prev_wa = handle_reg;
        prev_wd = '0;
        unique case (cmd.wr_op)
            tlsf_pkg::WR_NONE:
            begin
                head_we = 1'b0;
            end
            tlsf_pkg::WR_INS_A:
            begin
                prev_we = 1'b1;
                next_we = 1'b1;
                if (head_valid_reg)
                begin
                    next_wd.valid  = 1'b1;
                    next_wd.handle = head_rdata_reg;
                end
                head_we = 1'b1;
                head_wd = handle_reg;
            end
            tlsf_pkg::WR_INS_B:
            begin
                prev_we        = head_valid_reg;
                prev_wa        = head_rdata_reg;
                prev_wd.valid  = 1'b1;
                prev_wd.handle = handle_reg;
            end
            tlsf_pkg::WR_REM_A:
            begin
                prev_we = next_rdata_reg.valid;
                prev_wa = next_rdata_reg.handle;
                prev_wd = prev_rdata_reg;
                next_we = 1'b1;
                next_wa = prev_rdata_reg.handle;
                next_wd = next_rdata_reg;
            end
            tlsf_pkg::WR_REM_B:
            begin
                prev_we = 1'b1;
                next_we = 1'b1;
            end
            tlsf_pkg::WR_POP_A:
            begin
                prev_we = 1'b1;
                prev_wa = head_rdata_reg;
                next_we = 1'b1;
                next_wa = head_rdata_reg;
                head_we = next_rdata_reg.valid;
                head_wd = next_rdata_reg.handle;
            end
            tlsf_pkg::WR_POP_B:
            begin
                prev_we = next_rdata_reg.valid;
                prev_wa = next_rdata_reg.handle;
            end
            default:
            begin
                head_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flmap_reg <= '0;
            for (int i = 0; i < tlsf_pkg::FIRST_LEVELS; i++)
            begin
                slmap_reg[i] <= '0;
            end
        end
        else if (cmd.wr_op == tlsf_pkg::WR_INS_A)
        begin
            flmap_reg[fl_reg]         <= 1'b1;
            slmap_reg[fl_reg][sl_reg] <= 1'b1;
        end
        else if (cmd.wr_op == tlsf_pkg::WR_POP_A && !next_rdata_reg.valid)
        begin
            // The popped block was the last one in its bin.
            slmap_reg[fl_reg] <= sl_clr;
            if (sl_clr == '0)
            begin
                flmap_reg[fl_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[bin_addr] <= head_wd;
        end
        if (cmd.rd_head)
        begin
            head_rdata_reg <= head_mem[bin_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        if (cmd.rd_links || cmd.rd_next)
        begin
            next_rdata_reg <= next_mem[next_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_wa] <= prev_wd;
        end
        if (cmd.rd_links)
        begin
            prev_rdata_reg <= prev_mem[handle_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.res_kind != tlsf_pkg::RES_NONE)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.res_kind)
            tlsf_pkg::RES_NONE:
            begin
                taken_handle_reg <= taken_handle_reg;
            end
            tlsf_pkg::RES_DONE:
            begin
                taken_handle_reg <= '0;
                status_reg       <= tlsf_pkg::ST_OK;
            end
            tlsf_pkg::RES_MISS:
            begin
                taken_handle_reg <= '0;
                status_reg       <= tlsf_pkg::ST_MISS;
            end
            tlsf_pkg::RES_TAKE:
            begin
                taken_handle_reg <= tlsf_pkg::HANDLE_W'(head_rdata_reg);
                status_reg       <= tlsf_pkg::ST_OK;
            end
            default:
            begin
                taken_handle_reg <= taken_handle_reg;
            end
        endcase
    end

    assign stat.req_type        = req_type_reg;
    assign stat.link_prev_valid = prev_rdata_reg.valid;
    assign stat.fl_miss         = miss_reg;
    assign stat.pick_hit        = srch_sl_hit_reg || (srch_fl_hit_reg && (|sl_row));
    assign stat.rem_match       = head_valid_reg && (head_rdata_reg == handle_reg);
    assign stat.out_free        = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign taken_handle = taken_handle_reg;
    assign status       = status_reg;

endmodule

// ===== src/two_level_bin_free_list_index_top.sv =====
// Two-level segregated-fit free block index. Free blocks are named by 8-bit
// handles and kept in doubly linked lists, one list per size bin; a bin is
// the position of the top set bit of the size (first level) and the four
// bits just below it (second level). Three requests are served: insert
// (req_type 0) pushes a block onto the head of its bin, find (req_type 1)
// rounds the size up to the next bin boundary and pops the head of the
// smallest non-empty bin that fits, and remove (req_type 2) unlinks the
// given block, which must currently be filed under the same size. Every
// request produces exactly one result: a successful find returns the popped
// handle with status 0, a find with no fitting block returns handle 0 and
// status 1, and all other requests return handle 0 and status 0. Sizes
// below sixteen are treated as sixteen. One request is worked on at a time
// by a sequencer that walks the head and link memories, each of which has a
// single write port, so no new request is accepted until the sequencer is
// done with the previous one. The result register frees the input side once
// the result is loaded, so a new request is accepted while the previous
// result still waits under stall; if that result is still waiting when
// the next one is ready, the sequencer holds in its last state until the
// register frees. No clearing pass is needed after reset: bin heads are
// qualified by the bitmaps, which reset clears at once. Removing a handle
// that was never inserted reads unwritten link entries and gives an
// undefined outcome.
module two_level_bin_free_list_index_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [tlsf_pkg::REQ_W-1:0]    req_type,
    input  logic [tlsf_pkg::SIZE_W-1:0]   block_size,
    input  logic [tlsf_pkg::HANDLE_W-1:0] block_handle,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tlsf_pkg::HANDLE_W-1:0] taken_handle,
    output logic                          status
);

    // Commands from the sequencer and status back from the datapath.
    tlsf_pkg::dp_cmd_t  cmd;
    tlsf_pkg::dp_stat_t stat;

    // The sequencer owns the request side of the handshake.
    tlsf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the bitmaps, the three memories and the result register.
    tlsf_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_type     (req_type),
        .block_size   (block_size),
        .block_handle (block_handle),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .taken_handle (taken_handle),
        .status       (status)
    );

endmodule

// ===== src/tlsf_chk.sv =====
module tlsf_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [tlsf_pkg::HANDLE_W-1:0] taken_handle,
    input logic                          status
);

    // An accepted request keeps the input side stalled through the level, slot and following sequencer states.
    property p_busy_after_accept;
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall ##1 in_stall ##1 in_stall;
    endproperty

    // A miss never carries a handle.
    property p_miss_no_handle;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && status == tlsf_pkg::ST_MISS) |-> (taken_handle == '0);
    endproperty

    // A new result appears only while a request is in flight.
    property p_result_from_request;
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall);
    endproperty

    // A stalled result holds.
    property p_result_holds;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(taken_handle) && $stable(status));
    endproperty

    a_busy_after_accept: assert property (p_busy_after_accept)
        else $error("input side accepted a second request too early");
    a_miss_no_handle: assert property (p_miss_no_handle)
        else $error("miss result carries a nonzero handle");
    a_result_from_request: assert property (p_result_from_request)
        else $error("result appeared with no request in flight");
    a_result_holds: assert property (p_result_holds)
        else $error("stalled result changed");

endmodule

bind two_level_bin_free_list_index_top tlsf_chk u_tlsf_chk (.*);

// ===== verif/free_index_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the free block index, keeps its own copy of the
// bitmaps, bin heads and block links, and compares every result with the
// outcome predicted for the oldest outstanding request.
module free_index_checker
    import tlsf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [REQ_W-1:0]    req_type,
    input  logic [SIZE_W-1:0]   block_size,
    input  logic [HANDLE_W-1:0] block_handle,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [HANDLE_W-1:0] taken_handle,
    input  logic                status,
    output int                  fail_count,
    output int                  pending_count
);

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic                status;
    } outcome_t;

    logic [FIRST_LEVELS-1:0] level_map;
    logic [SL_COUNT-1:0]     slot_map [FIRST_LEVELS];
    link_t                   bin_head [BIN_COUNT];
    link_t                   next_of  [BLOCK_COUNT];
    link_t                   prev_of  [BLOCK_COUNT];
    outcome_t                awaited  [$];

    function automatic int top_index(input int unsigned v);
        int unsigned rest;
        int          idx;
        rest = v;
        idx  = 0;
        while (rest > 1) begin
            rest = rest >> 1;
            idx++;
        end
        return idx;
    endfunction

    function automatic int bottom_index(input logic [31:0] v);
        int idx;
        idx = 0;
        while (idx < 31 && !v[idx]) begin
            idx++;
        end
        return idx;
    endfunction

    function automatic int unsigned raised(input int unsigned s);
        return (s < SL_COUNT) ? SL_COUNT : s;
    endfunction

    // The size must already be at least the second-level count.
    function automatic void split_size(input int unsigned s, output int fl, output int sl);
        fl = top_index(s);
        sl = int'(s >> (fl - SL_BITS)) - SL_COUNT;
    endfunction

    // Bin under which a block of this size is filed; oversize goes to the last bin.
    function automatic void filing_bin(input int unsigned s, output int fl, output int sl);
        split_size(raised(s), fl, sl);
        if (fl >= FIRST_LEVELS) begin
            fl = FIRST_LEVELS - 1;
            sl = SL_COUNT - 1;
        end
    endfunction

    function automatic link_t pop_head(input int fl, input int sl);
        int    bin;
        int    h;
        link_t head;
        link_t succ;
        bin  = fl * SL_COUNT + sl;
        head = bin_head[bin];
        if (!head.valid) begin
            return '0;
        end
        h    = head.handle;
        succ = next_of[h];
        if (!succ.valid) begin
            slot_map[fl][sl] = 1'b0;
            if (slot_map[fl] == '0) begin
                level_map[fl] = 1'b0;
            end
            bin_head[bin] = '0;
        end
        else begin
            prev_of[succ.handle] = '0;
            bin_head[bin]        = succ;
        end
        next_of[h] = '0;
        prev_of[h] = '0;
        return head;
    endfunction

    function automatic outcome_t predict(input logic [REQ_W-1:0] kind,
                                         input logic [SIZE_W-1:0] req_size,
                                         input logic [HANDLE_W-1:0] hnd);
        outcome_t    res;
        int          fl;
        int          sl;
        int          f2;
        int          bin;
        int          h;
        int unsigned rounded;
        logic [31:0] slots;
        logic [31:0] levels;
        link_t       self;
        link_t       p;
        link_t       n;
        link_t       got;
        logic        hit;
        res.handle  = '0;
        res.status  = ST_OK;
        h           = hnd;
        self.valid  = 1'b1;
        self.handle = hnd;
        case (kind)
            REQ_INSERT: begin
                filing_bin(req_size, fl, sl);
                bin = fl * SL_COUNT + sl;
                prev_of[h] = '0;
                next_of[h] = '0;
                if (bin_head[bin].valid) begin
                    prev_of[bin_head[bin].handle] = self;
                    next_of[h] = bin_head[bin];
                end
                bin_head[bin]    = self;
                level_map[fl]    = 1'b1;
                slot_map[fl][sl] = 1'b1;
            end
            REQ_REMOVE: begin
                p = prev_of[h];
                n = next_of[h];
                if (!p.valid) begin
                    // Only the head of the bin for the given size can be unlinked here.
                    filing_bin(req_size, fl, sl);
                    if (bin_head[fl * SL_COUNT + sl] == self) begin
                        void'(pop_head(fl, sl));
                    end
                end
                else begin
                    if (n.valid) begin
                        prev_of[n.handle] = p;
                    end
                    next_of[p.handle] = n;
                    prev_of[h] = '0;
                    next_of[h] = '0;
                end
            end
            REQ_FIND: begin
                hit = 1'b0;
                got = '0;
                split_size(raised(req_size), fl, sl);
                rounded = raised(req_size) + (32'd1 << (fl - SL_BITS)) - 1;
                split_size(rounded, fl, sl);
                if (fl < FIRST_LEVELS) begin
                    slots = 32'(slot_map[fl]) & (32'hFFFF_FFFF << sl);
                    if (slots != 0) begin
                        got = pop_head(fl, bottom_index(slots));
                        hit = 1'b1;
                    end
                    else begin
                        levels = 32'(level_map) & (32'hFFFF_FFFF << (fl + 1));
                        if (levels != 0) begin
                            f2 = bottom_index(levels);
                            if (f2 < FIRST_LEVELS && slot_map[f2] != '0) begin
                                got = pop_head(f2, bottom_index(32'(slot_map[f2])));
                                hit = 1'b1;
                            end
                        end
                    end
                end
                if (hit && got.valid) begin
                    res.handle = HANDLE_W'(got.handle);
                end
                else begin
                    res.status = ST_MISS;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        outcome_t exp_res;
        if (!rst_n) begin
            level_map = '0;
            for (int i = 0; i < FIRST_LEVELS; i++) begin
                slot_map[i] = '0;
            end
            for (int i = 0; i < BIN_COUNT; i++) begin
                bin_head[i] = '0;
            end
            for (int i = 0; i < BLOCK_COUNT; i++) begin
                next_of[i] = '0;
                prev_of[i] = '0;
            end
            awaited.delete();
            fail_count    = 0;
            pending_count = 0;
        end
        else begin
            if (in_valid && !in_stall) begin
                awaited.push_back(predict(req_type, block_size, block_handle));
            end
            if (out_valid && !out_stall) begin
                if (awaited.size() == 0) begin
                    $display("%0t: result with no request outstanding, handle %0d status %0d",
                             $time, taken_handle, status);
                    fail_count++;
                end
                else begin
                    exp_res = awaited.pop_front();
                    if (taken_handle !== exp_res.handle) begin
                        $display("%0t: taken_handle mismatch, expected %0d, actual %0d",
                                 $time, exp_res.handle, taken_handle);
                        fail_count++;
                    end
                    if (status !== exp_res.status) begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, exp_res.status, status);
                        fail_count++;
                    end
                end
            end
            pending_count = awaited.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

// Top level of the free block index testbench. It generates the clock and
// the single reset, drives the request channel and the stall of the result
// channel, and gives the verdict. All prediction and comparison happen in
// the checker that sits beside the block.
module tb_top
    import tlsf_pkg::*;
;

    // Request code that the block must ignore.
    localparam logic [REQ_W-1:0] REQ_UNDEFINED = 2'd3;

    localparam int RANDOM_ITEMS = 1150;
    // Far above the length of the slowest correct run.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 24;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [REQ_W-1:0]    req_type;
    logic [SIZE_W-1:0]   block_size;
    logic [HANDLE_W-1:0] block_handle;
    logic                out_valid;
    logic                out_stall;
    logic [HANDLE_W-1:0] taken_handle;
    logic                status;

    int fail_count;
    int pending_count;
    int cycle_count;

    // When set, neither side inserts idle cycles, so requests go back to back.
    bit quiet_phase;

    // Loose bookkeeping of which handles are filed in the index. It only
    // steers the stimulus toward well-formed sequences; it is never checked.
    bit                ever_filed    [BLOCK_COUNT];
    bit                believed_free [BLOCK_COUNT];
    logic [SIZE_W-1:0] filed_size    [BLOCK_COUNT];
    logic [REQ_W-1:0]  issued_kinds  [$];

    two_level_bin_free_list_index_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .block_size   (block_size),
        .block_handle (block_handle),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .taken_handle (taken_handle),
        .status       (status)
    );

    free_index_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .block_size    (block_size),
        .block_handle  (block_handle),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .taken_handle  (taken_handle),
        .status        (status),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Idle cycles before the next request or the next result acceptance.
    function automatic int idle_draw();
        return quiet_phase ? 0 : int'($urandom_range(0, 4));
    endfunction

    // Most sizes fall in the lower levels so that finds hit often, but every
    // level and the full 24-bit range are reached too.
    function automatic logic [SIZE_W-1:0] random_size();
        int                lvl;
        logic [SIZE_W-1:0] s;
        if ($urandom_range(0, 19) == 0) begin
            return SIZE_W'($urandom);
        end
        lvl = ($urandom_range(0, 3) != 0) ? int'($urandom_range(4, 12))
                                          : int'($urandom_range(0, 23));
        if (lvl < SL_BITS) begin
            return SIZE_W'($urandom_range(0, SL_COUNT - 1));
        end
        s = SIZE_W'($urandom) & ((SIZE_W'(1) << lvl) - 1);
        return s | (SIZE_W'(1) << lvl);
    endfunction

    // Scans from a random start for a handle in the wanted state; -1 if none.
    function automatic int pick_handle(input bit want_free, input bit filed_only);
        int start;
        int h;
        start = $urandom_range(0, BLOCK_COUNT - 1);
        for (int i = 0; i < BLOCK_COUNT; i++) begin
            h = (start + i) % BLOCK_COUNT;
            if (believed_free[h] == want_free && (!filed_only || ever_filed[h])) begin
                return h;
            end
        end
        return -1;
    endfunction

    // Presents one request after a random gap and holds it until it is
    // accepted. Called and returning at a falling edge.
    task automatic issue_request(input logic [REQ_W-1:0] kind,
                                 input logic [SIZE_W-1:0] req_size,
                                 input logic [HANDLE_W-1:0] hnd);
        int gap;
        gap = idle_draw();
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_type     = kind;
        block_size   = req_size;
        block_handle = hnd;
        in_valid     = 1'b1;
        do @(posedge clk); while (in_stall);
        issued_kinds.push_back(kind);
        if (kind == REQ_INSERT) begin
            ever_filed[hnd]    = 1'b1;
            believed_free[hnd] = 1'b1;
            filed_size[hnd]    = req_size;
        end
        else if (kind == REQ_REMOVE && req_size == filed_size[hnd]) begin
            believed_free[hnd] = 1'b0;
        end
        @(negedge clk);
    endtask

    // A successful find takes its block out of the index.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall && issued_kinds.size() != 0) begin
            if (issued_kinds.pop_front() == REQ_FIND && status == ST_OK) begin
                believed_free[taken_handle] = 1'b0;
            end
        end
    end

    // Result side: for every result, stall a random number of cycles while
    // it waits, then accept it. Some stall also falls while nothing waits.
    initial begin
        int hold;
        out_stall = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever begin
            hold = idle_draw();
            if (hold > 0) begin
                out_stall = 1'b1;
                while (hold > 0) begin
                    @(posedge clk);
                    if (out_valid) begin
                        hold--;
                    end
                    @(negedge clk);
                end
            end
            out_stall = 1'b0;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top failed");
        $finish;
    end

    initial begin
        int                h;
        int                pick;
        int                done_items;
        logic [SIZE_W-1:0] req_size;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        req_type     = REQ_INSERT;
        block_size   = '0;
        block_handle = '0;
        quiet_phase  = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part. A find on the empty index must miss.
        issue_request(REQ_FIND, 24'd0, 8'h00);
        // A size below sixteen is filed as sixteen; the largest size lands
        // in the last bin of the top level.
        issue_request(REQ_INSERT, 24'd0, 8'h00);
        issue_request(REQ_INSERT, 24'hFF_FFFF, 8'hFF);
        issue_request(REQ_INSERT, 24'd16, 8'h01);
        issue_request(REQ_INSERT, 24'd17, 8'h02);
        // Rounds up to sixteen and pops the head of the first bin.
        issue_request(REQ_FIND, 24'd1, 8'h00);
        // Rounding the largest size moves past the top level, so it misses.
        issue_request(REQ_FIND, 24'hFF_FFFF, 8'h00);
        // Fits only the top-level block.
        issue_request(REQ_FIND, 24'h80_0000, 8'h00);
        // That block was popped, so its links are clear and it is no longer
        // a head: the remove is ignored.
        issue_request(REQ_REMOVE, 24'hFF_FFFF, 8'hFF);
        // Remove of a block that has a predecessor in its bin.
        issue_request(REQ_INSERT, 24'd1000, 8'h03);
        issue_request(REQ_INSERT, 24'd1000, 8'h04);
        issue_request(REQ_REMOVE, 24'd1000, 8'h03);
        // A head given with the wrong size is left alone; with the right one
        // it is unlinked and the bin empties.
        issue_request(REQ_INSERT, 24'd2000, 8'h05);
        issue_request(REQ_REMOVE, 24'd50, 8'h05);
        issue_request(REQ_REMOVE, 24'd2000, 8'h05);
        issue_request(REQ_REMOVE, 24'd1000, 8'h04);
        // Unknown request types only return an empty result.
        issue_request(REQ_UNDEFINED, 24'hAA_AAAA, 8'hAA);
        issue_request(REQ_UNDEFINED, 24'h55_5555, 8'h55);
        // A find whose own level is empty moves up to a higher level.
        issue_request(REQ_INSERT, 24'h01_0000, 8'h55);
        issue_request(REQ_FIND, 24'd100, 8'hAA);
        // A find that skips an empty slot within its own level.
        issue_request(REQ_INSERT, 24'd17, 8'hAA);
        issue_request(REQ_FIND, 24'd16, 8'h00);
        issue_request(REQ_FIND, 24'd16, 8'h00);

        // Random part: mostly well-formed traffic on the tracked handles,
        // with a little noise such as wrong sizes and repeated inserts.
        done_items = 0;
        while (done_items < RANDOM_ITEMS) begin
            if (done_items % 150 == 0) begin
                quiet_phase = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 42) begin
                h = pick_handle(1'b0, 1'b0);
                if (h < 0 || $urandom_range(0, 29) == 0) begin
                    h = $urandom_range(0, BLOCK_COUNT - 1);
                end
                issue_request(REQ_INSERT, random_size(), HANDLE_W'(h));
                done_items++;
            end
            else if (pick < 72) begin
                h = pick_handle(1'b1, 1'b1);
                if (h >= 0 && $urandom_range(0, 1) == 1) begin
                    req_size = filed_size[h] - SIZE_W'($urandom_range(0, 3));
                end
                else begin
                    req_size = random_size();
                end
                issue_request(REQ_FIND, req_size, HANDLE_W'($urandom));
                done_items++;
            end
            else if (pick < 96) begin
                // Only handles that were filed at some point may be removed.
                h = pick_handle(1'b1, 1'b1);
                if (h < 0) begin
                    h = pick_handle(1'b0, 1'b1);
                end
                if (h >= 0) begin
                    req_size = ($urandom_range(0, 9) == 0) ? random_size() : filed_size[h];
                    issue_request(REQ_REMOVE, req_size, HANDLE_W'(h));
                    done_items++;
                end
            end
            else begin
                issue_request(REQ_UNDEFINED, SIZE_W'($urandom), HANDLE_W'($urandom));
            end
        end
        in_valid = 1'b0;

        // Drain: wait for every outstanding result, then keep the simulation running
        // so that a stray extra result would still be caught.
        while (pending_count != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("tb_top passed");
        end
        else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/tlsf_pkg.sv
src/tlsf_ctrl.sv
src/tlsf_dp.sv
src/two_level_bin_free_list_index_top.sv
src/tlsf_chk.sv
verif/free_index_checker.sv
verif/tb_top.sv
